// ===== hdl/cst_pkg.sv =====
package cst_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int LENGTH_BITS = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

    typedef logic [OFFSET_BITS-1:0] t_off;
    typedef logic [LENGTH_BITS-1:0] t_len;
    typedef logic [3:0]             t_tok;

    // Input item kinds.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Token kinds.
    localparam t_tok TK_LPAREN  = 4'd0;
    localparam t_tok TK_RPAREN  = 4'd1;
    localparam t_tok TK_LBRACE  = 4'd2;
    localparam t_tok TK_RBRACE  = 4'd3;
    localparam t_tok TK_SEMI    = 4'd4;
    localparam t_tok TK_IDENT   = 4'd5;
    localparam t_tok TK_CONST   = 4'd6;
    localparam t_tok TK_INT     = 4'd7;
    localparam t_tok TK_VOID    = 4'd8;
    localparam t_tok TK_RETURN  = 4'd9;
    localparam t_tok TK_UNKNOWN = 4'd10;
    localparam t_tok TK_END     = 4'd11;
    localparam t_tok TK_ERROR   = 4'd12;

    // Word modes.
    localparam logic [1:0] WM_NONE   = 2'd0;
    localparam logic [1:0] WM_UNDER  = 2'd1;
    localparam logic [1:0] WM_LETTER = 2'd2;
    localparam logic [1:0] WM_DIGIT  = 2'd3;

    localparam int NUM_KW = 3;
    localparam logic [2:0] KW_LEN  [NUM_KW] = '{3'd3, 3'd4, 3'd6};
    localparam t_tok       KW_KIND [NUM_KW] = '{TK_INT, TK_VOID, TK_RETURN};

    localparam int TDATA_BITS = ((4 + OFFSET_BITS + LENGTH_BITS + 7) / 8) * 8;

    typedef struct packed {
        t_tok kind;
        t_off start;
        t_len len;
    } t_rec;

    // One queue entry: an optional word record followed by an optional
    // record for the item itself.
    typedef struct packed {
        logic has_word;
        t_rec word;
        logic has_tok;
        t_rec tok;
    } t_entry;

    function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (k)
            0: begin
                case (pos)
                    3'd0: c = "i";
                    3'd1: c = "n";
                    3'd2: c = "t";
                    default: c = 8'h00;
                endcase
            end
            1: begin
                case (pos)
                    3'd0: c = "v";
                    3'd1: c = "o";
                    3'd2: c = "i";
                    3'd3: c = "d";
                    default: c = 8'h00;
                endcase
            end
            default: begin
                case (pos)
                    3'd0: c = "r";
                    3'd1: c = "e";
                    3'd2: c = "t";
                    3'd3: c = "u";
                    3'd4: c = "r";
                    3'd5: c = "n";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_digit(c) || is_letter(c) || (c == "_");
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
               (c == 8'h0B) || (c == 8'h0C);
    endfunction

    // Keyword candidates that survive appending c at position pos.
    function automatic logic [NUM_KW-1:0] match_next(input logic [NUM_KW-1:0] bits,
                                                     input t_len pos,
                                                     input logic [7:0] c);
        logic [NUM_KW-1:0] res;
        res = '0;
        for (int k = 0; k < NUM_KW; k++) begin
            if (bits[k] && (pos < t_len'(KW_LEN[k])) && (kw_char(k, pos[2:0]) == c)) begin
                res[k] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/cst_front.sv =====
module cst_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_ready,
    input  logic [1:0]      i_kind,
    input  logic [7:0]      i_char,
    output logic            o_push,
    output cst_pkg::t_entry o_entry
);
    import cst_pkg::*;

    logic [1:0]        r_mode,   n_mode;
    t_off              r_start,  n_start;
    t_len              r_len,    n_len;
    logic [NUM_KW-1:0] r_match,  n_match;
    logic              r_digits, n_digits;
    t_off              r_offset, n_offset;

    t_entry ent;
    t_tok   word_kind;
    logic   accept;

    assign accept = i_valid && i_ready;

    // Kind of the pending word if it were closed now.
    always_comb begin
        word_kind = TK_IDENT;
        if (r_mode == WM_LETTER) begin
            for (int k = 0; k < NUM_KW; k++) begin
                if (r_match[k] && (r_len == t_len'(KW_LEN[k]))) begin
                    word_kind = KW_KIND[k];
                end
            end
        end else if (r_mode == WM_DIGIT) begin
            word_kind = r_digits ? TK_CONST : TK_UNKNOWN;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_len    = r_len;
        n_match  = r_match;
        n_digits = r_digits;
        n_offset = r_offset;
        ent      = '0;
        ent.word = '{kind: word_kind, start: r_start, len: r_len};
        if (accept) begin
            case (i_kind) inside
                KIND_END, KIND_ERROR: begin
                    ent.has_word = (r_mode != WM_NONE);
                    ent.has_tok  = 1'b1;
                    ent.tok      = '{kind: (i_kind == KIND_END) ? TK_END : TK_ERROR,
                                     start: r_offset, len: '0};
                    n_mode   = WM_NONE;
                    n_start  = '0;
                    n_len    = '0;
                    n_match  = '0;
                    n_digits = 1'b1;
                    n_offset = '0;
                end
                KIND_CHAR: begin
                    n_offset = r_offset + t_off'(1);
                    if ((r_mode != WM_NONE) && is_word(i_char)) begin
                        n_match = match_next(r_match, r_len, i_char);
                        if (!is_digit(i_char)) begin
                            n_digits = 1'b0;
                        end
                        if (r_len != '1) begin
                            n_len = r_len + t_len'(1);
                        end
                    end else begin
                        ent.has_word = (r_mode != WM_NONE);
                        n_mode   = WM_NONE;
                        n_start  = '0;
                        n_len    = '0;
                        n_match  = '0;
                        n_digits = 1'b1;
                        if (is_word(i_char)) begin
                            n_start = r_offset;
                            n_len   = t_len'(1);
                            if (i_char == "_") begin
                                n_mode = WM_UNDER;
                            end else if (is_letter(i_char)) begin
                                n_mode  = WM_LETTER;
                                n_match = match_next('1, '0, i_char);
                            end else begin
                                n_mode = WM_DIGIT;
                            end
                        end else if (!is_space(i_char)) begin
                            ent.has_tok   = 1'b1;
                            ent.tok.start = r_offset;
                            ent.tok.len   = t_len'(1);
                            case (i_char)
                                "(":     ent.tok.kind = TK_LPAREN;
                                ")":     ent.tok.kind = TK_RPAREN;
                                "{":     ent.tok.kind = TK_LBRACE;
                                "}":     ent.tok.kind = TK_RBRACE;
                                ";":     ent.tok.kind = TK_SEMI;
                                default: ent.tok.kind = TK_UNKNOWN;
                            endcase
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_push  = accept && (ent.has_word || ent.has_tok);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= WM_NONE;
            r_start  <= '0;
            r_len    <= '0;
            r_match  <= '0;
            r_digits <= 1'b1;
            r_offset <= '0;
        end else begin
            r_mode   <= n_mode;
            r_start  <= n_start;
            r_len    <= n_len;
            r_match  <= n_match;
            r_digits <= n_digits;
            r_offset <= n_offset;
        end
    end

endmodule

// ===== hdl/cst_fifo.sv =====
module cst_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cst_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output cst_pkg::t_entry o_head
);
    import cst_pkg::*;

    t_entry               r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr, n_wr;
    logic [QPTR_BITS-1:0] r_rd, n_rd;
    logic [QPTR_BITS:0]   r_count, n_count;

    assign o_full  = (r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = r_wr + QPTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd = r_rd + QPTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (QPTR_BITS + 1)'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - (QPTR_BITS + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== hdl/cst_back.sv =====
module cst_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  cst_pkg::t_entry i_head,
    input  logic            i_ready,
    output logic            o_valid,
    output cst_pkg::t_rec   o_rec,
    output logic            o_last,
    output logic            o_pop
);
    import cst_pkg::*;

    // Set once the word record of the head entry has gone out.
    logic r_phase, n_phase;
    logic show_word;
    logic fire;

    assign show_word = i_head.has_word && !r_phase;
    assign o_valid   = !i_empty;
    assign o_rec     = show_word ? i_head.word : i_head.tok;
    assign o_last    = !(show_word && i_head.has_tok);
    assign fire      = o_valid && i_ready;
    assign o_pop     = fire && o_last;

    always_comb begin
        n_phase = r_phase;
        if (o_pop) begin
            n_phase = 1'b0;
        end else if (fire) begin
            n_phase = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else begin
            r_phase <= n_phase;
        end
    end

endmodule

// ===== hdl/c_subset_tokenizer.sv =====
// Byte-serial tokenizer for a small C subset. Each input item is a source
// byte (tuser kind character) or an end-of-stream or read-error marker; each
// output item is a token record giving its kind, the offset of its first byte
// within the stream and its length in bytes, with tlast set on the final
// record caused by an input item. The block takes one input item per cycle.
// A byte that closes a pending word and is itself a token, and every end or
// error marker that closes a word, gives two records, which leave one by one;
// a four-entry queue between the classifying front and the record-issuing
// back absorbs such bursts and output stalls, and input is held off only
// while that queue is full. Each record is registered in the queue, behind
// any waiting records, before it reaches the output. After an end or error
// marker the offset restarts at zero, so a fresh stream may follow at once.
module c_subset_tokenizer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] char_code
    input  logic [7:0]                     s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [3:0] token_kind, [35:4] start_offset, [51:36] token_length, rest zero
    output logic [cst_pkg::TDATA_BITS-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import cst_pkg::*;

    logic   push;
    logic   pop;
    logic   full;
    logic   empty;
    t_entry entry;
    t_entry head;
    t_rec   rec;

    assign s_axis_tready = !full;

    // The front keeps the word state and turns each taken item that gives a record into a queue entry.
    cst_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_ready (s_axis_tready),
        .i_kind  (s_axis_tuser),
        .i_char  (s_axis_tdata),
        .o_push  (push),
        .o_entry (entry)
    );

    cst_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    // The back splits each entry into one or two output records.
    cst_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_rec   (rec),
        .o_last  (m_axis_tlast),
        .o_pop   (pop)
    );

    assign m_axis_tdata = TDATA_BITS'({rec.len, rec.start, rec.kind});

    // An end marker always leaves a record waiting in the next cycle.
    a_end_gives_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == KIND_END)) |=> m_axis_tvalid)
        else $error("end marker produced no record");

    // Only a word record can be followed by another record of the same item.
    a_non_last_is_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |->
        ((m_axis_tdata[3:0] >= TK_IDENT) && (m_axis_tdata[3:0] <= TK_UNKNOWN)))
        else $error("non-final record is not a word");

    // End and error records always close their item.
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && ((m_axis_tdata[3:0] == TK_END) ||
                           (m_axis_tdata[3:0] == TK_ERROR))) |-> m_axis_tlast)
        else $error("end or error record without tlast");

endmodule
